// File: src/grid_ray_march_distance_assert.svh
// assertion macros for the grid ray march distance block
`ifndef GRID_RAY_MARCH_DISTANCE_ASSERT_SVH
`define GRID_RAY_MARCH_DISTANCE_ASSERT_SVH
`ifndef SYNTHESIS
`define GRM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("grm assertion failed");
`define GRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("grm assertion failed");
`else
`define GRM_ASSERT_SAME(label, ante, cons)
`define GRM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: src/grm_pkg.sv
// shared types, constants and sine table of the grid ray march block
package grm_pkg;

    localparam int POS_W    = 34;  // signed Q.16 position
    localparam int PIX_W    = POS_W - 17;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 64;
    localparam int RND_W    = 40;
    localparam int MAG_W    = RND_W - 14;
    localparam int SQ_W     = 62;
    localparam int STEP_W   = 24;
    localparam int DVD_W    = 24;
    localparam int CNT_W    = 5;
    localparam int DIST_BITS = 23;
    localparam int TRIG_W   = 15;

    localparam logic [STEP_W-1:0] STEP_MIN = 24'd16384;  // quarter pixel

    // configuration register indexes
    localparam logic [1:0] REG_ORIGIN_X     = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y     = 2'd1;
    localparam logic [1:0] REG_CELL_SIZE    = 2'd2;
    localparam logic [1:0] REG_INITIAL_STEP = 2'd3;

    typedef struct packed {
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [7:0]  cell_size;
        logic [7:0]  initial_step;
    } cfg_t;

    typedef struct packed {
        logic [19:0] start_x;
        logic [19:0] start_y;
        logic [8:0]  ray_angle;
    } cast_cmd_t;

    typedef struct packed {
        logic [15:0] distance;
        logic [19:0] end_x;
        logic [19:0] end_y;
    } result_t;

    typedef struct packed {
        logic              neg;
        logic [TRIG_W-1:0] mag;
    } trig_t;

    // quarter-wave sine, Q1.14
    function automatic logic [TRIG_W-1:0] sine_q14(input logic [6:0] idx);
        logic [TRIG_W-1:0] v;
        unique case (idx)
            7'd0: v = 15'd0;         7'd1: v = 15'd286;       7'd2: v = 15'd572;
            7'd3: v = 15'd857;       7'd4: v = 15'd1143;      7'd5: v = 15'd1428;
            7'd6: v = 15'd1713;      7'd7: v = 15'd1997;      7'd8: v = 15'd2280;
            7'd9: v = 15'd2563;      7'd10: v = 15'd2845;     7'd11: v = 15'd3126;
            7'd12: v = 15'd3406;     7'd13: v = 15'd3686;     7'd14: v = 15'd3964;
            7'd15: v = 15'd4240;     7'd16: v = 15'd4516;     7'd17: v = 15'd4790;
            7'd18: v = 15'd5063;     7'd19: v = 15'd5334;     7'd20: v = 15'd5604;
            7'd21: v = 15'd5872;     7'd22: v = 15'd6138;     7'd23: v = 15'd6402;
            7'd24: v = 15'd6664;     7'd25: v = 15'd6924;     7'd26: v = 15'd7182;
            7'd27: v = 15'd7438;     7'd28: v = 15'd7692;     7'd29: v = 15'd7943;
            7'd30: v = 15'd8192;     7'd31: v = 15'd8438;     7'd32: v = 15'd8682;
            7'd33: v = 15'd8923;     7'd34: v = 15'd9162;     7'd35: v = 15'd9397;
            7'd36: v = 15'd9630;     7'd37: v = 15'd9860;     7'd38: v = 15'd10087;
            7'd39: v = 15'd10311;    7'd40: v = 15'd10531;    7'd41: v = 15'd10749;
            7'd42: v = 15'd10963;    7'd43: v = 15'd11174;    7'd44: v = 15'd11381;
            7'd45: v = 15'd11585;    7'd46: v = 15'd11786;    7'd47: v = 15'd11982;
            7'd48: v = 15'd12176;    7'd49: v = 15'd12365;    7'd50: v = 15'd12551;
            7'd51: v = 15'd12733;    7'd52: v = 15'd12911;    7'd53: v = 15'd13085;
            7'd54: v = 15'd13255;    7'd55: v = 15'd13421;    7'd56: v = 15'd13583;
            7'd57: v = 15'd13741;    7'd58: v = 15'd13894;    7'd59: v = 15'd14044;
            7'd60: v = 15'd14189;    7'd61: v = 15'd14330;    7'd62: v = 15'd14466;
            7'd63: v = 15'd14598;    7'd64: v = 15'd14726;    7'd65: v = 15'd14849;
            7'd66: v = 15'd14968;    7'd67: v = 15'd15082;    7'd68: v = 15'd15191;
            7'd69: v = 15'd15296;    7'd70: v = 15'd15396;    7'd71: v = 15'd15491;
            7'd72: v = 15'd15582;    7'd73: v = 15'd15668;    7'd74: v = 15'd15749;
            7'd75: v = 15'd15826;    7'd76: v = 15'd15897;    7'd77: v = 15'd15964;
            7'd78: v = 15'd16026;    7'd79: v = 15'd16083;    7'd80: v = 15'd16135;
            7'd81: v = 15'd16182;    7'd82: v = 15'd16225;    7'd83: v = 15'd16262;
            7'd84: v = 15'd16294;    7'd85: v = 15'd16322;    7'd86: v = 15'd16344;
            7'd87: v = 15'd16362;    7'd88: v = 15'd16374;    7'd89: v = 15'd16382;
            7'd90: v = 15'd16384;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    // magnitude and sign of sin(deg), deg in 0..359
    function automatic trig_t sine_of(input logic [8:0] deg);
        trig_t      t;
        logic [8:0] idx;
        t.neg = (deg > 9'd180);
        if (deg <= 9'd90) begin
            idx = deg;
        end else if (deg <= 9'd180) begin
            idx = 9'd180 - deg;
        end else if (deg <= 9'd270) begin
            idx = deg - 9'd180;
        end else begin
            idx = 9'd360 - deg;
        end
        t.mag = sine_q14(idx[6:0]);
        return t;
    endfunction

endpackage

// File: src/grm_ram.sv
// generic single-port-write ram with registered read
module grm_ram #(
    parameter int DATA_W = 1,
    parameter int DEPTH  = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// File: src/grm_engine.sv
// ray march sequencer around one shared multiplier, divider step and root step
module grm_engine #(
    parameter int MAP_COLUMNS = 16,
    parameter int MAP_ROWS    = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  grm_pkg::cast_cmd_t       cmd,
    input  grm_pkg::cfg_t            cfg,
    output logic                     rd_en,
    output logic [$clog2(MAP_COLUMNS*MAP_ROWS)-1:0] rd_addr,
    input  logic                     rd_data,
    input  logic                     res_ready,
    output logic                     idle,
    output logic                     done,
    output grm_pkg::result_t         res
);
    import grm_pkg::*;

    localparam int COL_W  = $clog2(MAP_COLUMNS);
    localparam int ROW_W  = $clog2(MAP_ROWS);
    localparam int ADDR_W = $clog2(MAP_COLUMNS * MAP_ROWS);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_CHK  = 5'd1;
    localparam logic [4:0] ST_DIVX = 5'd2;
    localparam logic [4:0] ST_DIVY = 5'd3;
    localparam logic [4:0] ST_RD   = 5'd4;
    localparam logic [4:0] ST_EVAL = 5'd5;
    localparam logic [4:0] ST_MULX = 5'd6;
    localparam logic [4:0] ST_MULY = 5'd7;
    localparam logic [4:0] ST_MULD = 5'd8;
    localparam logic [4:0] ST_STEP = 5'd9;
    localparam logic [4:0] ST_SQX  = 5'd10;
    localparam logic [4:0] ST_SQY  = 5'd11;
    localparam logic [4:0] ST_SUM  = 5'd12;
    localparam logic [4:0] ST_ROOT = 5'd13;
    localparam logic [4:0] ST_DIVD = 5'd14;
    localparam logic [4:0] ST_DONE = 5'd15;

    logic [4:0] state_reg, state_next;
    logic       first_reg, first_next;
    logic       sneg_reg, sneg_next, cneg_reg, cneg_next;
    logic [TRIG_W-1:0] sm_reg, sm_next, cm_reg, cm_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic signed [POS_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [POS_W-1:0] lx_reg, lx_next, ly_reg, ly_next;
    logic signed [POS_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [POS_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [7:0]        rem_reg, rem_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next, q_reg, q_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SQ_W-1:0]   acc_reg, acc_next, root_reg, root_next, bit_reg, bit_next;
    logic [15:0]       dist_reg, dist_next;

    logic [7:0]        cs;
    logic [8:0]        ang_fold, ang_cos_sum, ang_cos;
    trig_t             sin_t, cos_t;
    logic signed [POS_W-1:0] rx, ry, ex, ey;
    logic [POS_W-1:0]  ux_full, uy_full;
    logic [PIX_W-1:0]  rxp, ryp, lim_x, lim_y;
    logic              geo_blk;
    logic [8:0]        div_t, div_sub;
    logic              div_ge;
    logic [7:0]        rem_step;
    logic [DVD_W-1:0]  q_step;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [RND_W-1:0]  mag_rnd;
    logic signed [POS_W-1:0] mag_ext;
    logic [SQ_W-1:0]   sumrb, root_step;
    logic              root_ge;
    logic [STEP_W-1:0] step_half;
    logic              test_done, test_blk;
    logic [DIST_BITS-1:0] qd;
    logic [POS_W-9:0]  ex_clamp, ey_clamp;

    // direction from the folded angle
    always_comb begin
        ang_fold    = (cmd.ray_angle >= 9'd360) ? cmd.ray_angle - 9'd360 : cmd.ray_angle;
        ang_cos_sum = ang_fold + 9'd90;
        ang_cos     = (ang_cos_sum >= 9'd360) ? ang_cos_sum - 9'd360 : ang_cos_sum;
        sin_t       = sine_of(ang_fold);
        cos_t       = sine_of(ang_cos);
    end

    // map geometry of the candidate point
    always_comb begin
        cs      = (cfg.cell_size == 8'd0) ? 8'd1 : cfg.cell_size;
        rx      = cx_reg - $signed({{(POS_W-28){1'b0}}, cfg.origin_x, 16'b0});
        ry      = cy_reg - $signed({{(POS_W-28){1'b0}}, cfg.origin_y, 16'b0});
        rxp     = rx[POS_W-2:16];
        ryp     = ry[POS_W-2:16];
        lim_x   = PIX_W'(cs) * PIX_W'(MAP_COLUMNS);
        lim_y   = PIX_W'(cs) * PIX_W'(MAP_ROWS);
        geo_blk = rx[POS_W-1] | ry[POS_W-1] | (rxp >= lim_x) | (ryp >= lim_y);
    end

    // shared restoring divider step by the cell size
    always_comb begin
        div_t    = {rem_reg, dvd_reg[DVD_W-1]};
        div_sub  = div_t - {1'b0, cs};
        div_ge   = (div_t >= {1'b0, cs});
        rem_step = div_ge ? div_sub[7:0] : div_t[7:0];
        q_step   = {q_reg[DVD_W-2:0], div_ge};
    end

    // shared root step
    always_comb begin
        sumrb     = root_reg + bit_reg;
        root_ge   = (acc_reg >= sumrb);
        root_step = root_ge ? (root_reg >> 1) + bit_reg : root_reg >> 1;
    end

    // displacement magnitude rounded at Q.16, end point distances
    always_comb begin
        mag_rnd   = prod_reg[RND_W-1:0] + RND_W'(8192);
        mag_ext   = $signed(POS_W'(mag_rnd[RND_W-1:14]));
        step_half = step_reg >> 1;
        ex        = lx_reg - sx_reg;
        ey        = ly_reg - sy_reg;
        ux_full   = ex[POS_W-1] ? -ex : ex;
        uy_full   = ey[POS_W-1] ? -ey : ey;
        qd        = q_step[DIST_BITS-1:0];
    end

    // shared multiplier operand select
    always_comb begin
        unique case (state_reg)
            ST_MULX: begin
                mul_a = MUL_W'(sm_reg);
                mul_b = MUL_W'(step_reg);
            end
            ST_MULY: begin
                mul_a = MUL_W'(cm_reg);
                mul_b = MUL_W'(step_reg);
            end
            ST_SQX: begin
                mul_a = ux_full[MUL_W-1:0];
                mul_b = ux_full[MUL_W-1:0];
            end
            ST_SQY: begin
                mul_a = uy_full[MUL_W-1:0];
                mul_b = uy_full[MUL_W-1:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        first_next = first_reg;
        sneg_next  = sneg_reg;
        cneg_next  = cneg_reg;
        sm_next    = sm_reg;
        cm_next    = cm_reg;
        step_next  = step_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        lx_next    = lx_reg;
        ly_next    = ly_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        prod_next  = PROD_W'(mul_a) * PROD_W'(mul_b);
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        acc_next   = acc_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        dist_next  = dist_reg;
        test_done  = 1'b0;
        test_blk   = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    sx_next    = $signed({{(POS_W-28){1'b0}}, cmd.start_x, 8'b0});
                    sy_next    = $signed({{(POS_W-28){1'b0}}, cmd.start_y, 8'b0});
                    lx_next    = $signed({{(POS_W-28){1'b0}}, cmd.start_x, 8'b0});
                    ly_next    = $signed({{(POS_W-28){1'b0}}, cmd.start_y, 8'b0});
                    cx_next    = $signed({{(POS_W-28){1'b0}}, cmd.start_x, 8'b0});
                    cy_next    = $signed({{(POS_W-28){1'b0}}, cmd.start_y, 8'b0});
                    sm_next    = sin_t.mag;
                    sneg_next  = sin_t.neg;
                    cm_next    = cos_t.mag;
                    cneg_next  = cos_t.neg;
                    step_next  = {cfg.initial_step, 16'b0};
                    first_next = 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (geo_blk) begin
                    test_done = 1'b1;
                end else begin
                    rem_next   = 8'(rxp >> COL_W);
                    dvd_next   = {rxp[COL_W-1:0], {(DVD_W-COL_W){1'b0}}};
                    cnt_next   = CNT_W'(COL_W);
                    state_next = ST_DIVX;
                end
            end
            ST_DIVX: begin
                rem_next = rem_step;
                q_next   = q_step;
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    col_next   = q_step[COL_W-1:0];
                    rem_next   = 8'(ryp >> ROW_W);
                    dvd_next   = {ryp[ROW_W-1:0], {(DVD_W-ROW_W){1'b0}}};
                    cnt_next   = CNT_W'(ROW_W);
                    state_next = ST_DIVY;
                end
            end
            ST_DIVY: begin
                rem_next = rem_step;
                q_next   = q_step;
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    row_next   = q_step[ROW_W-1:0];
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                test_done = 1'b1;
                test_blk  = rd_data;
            end
            ST_MULX: begin
                state_next = ST_MULY;
            end
            ST_MULY: begin
                dx_next    = sneg_reg ? mag_ext : -mag_ext;
                state_next = ST_MULD;
            end
            ST_MULD: begin
                dy_next    = cneg_reg ? -mag_ext : mag_ext;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                cx_next    = lx_reg + dx_reg;
                cy_next    = ly_reg + dy_reg;
                state_next = ST_CHK;
            end
            ST_SQX: begin
                state_next = ST_SQY;
            end
            ST_SQY: begin
                acc_next   = prod_reg[SQ_W-1:0];
                state_next = ST_SUM;
            end
            ST_SUM: begin
                acc_next   = acc_reg + prod_reg[SQ_W-1:0];
                root_next  = '0;
                bit_next   = SQ_W'(1) << (SQ_W - 2);
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (root_ge) begin
                    acc_next = acc_reg - sumrb;
                end
                root_next = root_step;
                bit_next  = bit_reg >> 2;
                if (bit_reg[0]) begin
                    rem_next   = '0;
                    dvd_next   = {root_step[30:8], {(DVD_W-DIST_BITS){1'b0}}};
                    cnt_next   = CNT_W'(DIST_BITS);
                    state_next = ST_DIVD;
                end
            end
            ST_DIVD: begin
                rem_next = rem_step;
                q_next   = q_step;
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    dist_next  = (|qd[DIST_BITS-1:16]) ? 16'hFFFF : qd[15:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // outcome of one blocked test
        if (test_done) begin
            if (first_reg) begin
                first_next = 1'b0;
                state_next = (!test_blk && (step_reg > STEP_MIN)) ? ST_MULX : ST_SQX;
            end else if (!test_blk) begin
                lx_next    = cx_reg;
                ly_next    = cy_reg;
                state_next = ST_STEP;
            end else begin
                step_next  = step_half;
                state_next = (step_half > STEP_MIN) ? ST_MULX : ST_SQX;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            first_reg <= first_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        sneg_reg <= sneg_next;
        cneg_reg <= cneg_next;
        sm_reg   <= sm_next;
        cm_reg   <= cm_next;
        step_reg <= step_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        lx_reg   <= lx_next;
        ly_reg   <= ly_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        col_reg  <= col_next;
        row_reg  <= row_next;
        acc_reg  <= acc_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        dist_reg <= dist_next;
    end

    // map read and result
    always_comb begin
        rd_en        = (state_reg == ST_RD);
        rd_addr      = ADDR_W'(row_reg) * ADDR_W'(MAP_COLUMNS) + ADDR_W'(col_reg);
        idle         = (state_reg == ST_IDLE);
        done         = (state_reg == ST_DONE) && res_ready;
        ex_clamp     = lx_reg[POS_W-1:8];
        ey_clamp     = ly_reg[POS_W-1:8];
        res.distance = dist_reg;
        res.end_x    = (|ex_clamp[POS_W-9:20]) ? 20'hFFFFF : ex_clamp[19:0];
        res.end_y    = (|ey_clamp[POS_W-9:20]) ? 20'hFFFFF : ey_clamp[19:0];
    end
endmodule

// File: src/grid_ray_march_distance.sv
// grid ray march distance: wall map, config registers, handshakes and march engine
// a cell write goes into the map as it is accepted; a cast checks points along the ray,
//   halving its step on a hit, then divides the root distance by the cell size
// one item at a time: the march sequencer and its shared multiplier set the rate
// after reset the map is cleared one cell a cycle, all MAP_COLUMNS*MAP_ROWS cells,
//   and no item is accepted until that pass ends; config writes are always taken
module grid_ray_march_distance #(
    parameter int MAP_COLUMNS = 16,
    parameter int MAP_ROWS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [3:0]  s_cell_x,
    input  logic [3:0]  s_cell_y,
    input  logic        s_wall_bit,
    input  logic [19:0] s_start_x,
    input  logic [19:0] s_start_y,
    input  logic [8:0]  s_ray_angle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_distance,
    output logic [19:0] m_end_x,
    output logic [19:0] m_end_y,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_wdata
);
    import grm_pkg::*;

    localparam int DEPTH  = MAP_COLUMNS * MAP_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);

    cfg_t              cfg_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              clr_done_reg;
    logic              m_valid_reg;
    result_t           m_res_reg;

    logic              s_accept, wr_cell, in_range;
    logic              ram_we, ram_wd, ram_re, ram_rd;
    logic [ADDR_W-1:0] ram_wa, ram_ra;
    logic              eng_idle, eng_done, res_ready;
    cast_cmd_t         cmd;
    result_t           eng_res;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x     <= 12'd480;
            cfg_reg.origin_y     <= 12'd40;
            cfg_reg.cell_size    <= 8'd60;
            cfg_reg.initial_step <= 8'd60;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ORIGIN_X:     cfg_reg.origin_x     <= cfg_wdata;
                REG_ORIGIN_Y:     cfg_reg.origin_y     <= cfg_wdata;
                REG_CELL_SIZE:    cfg_reg.cell_size    <= cfg_wdata[7:0];
                REG_INITIAL_STEP: cfg_reg.initial_step <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // map clearing pass after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_done_reg <= 1'b0;
        end else if (!clr_done_reg) begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                clr_done_reg <= 1'b1;
            end else begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // input handshake and cell writes
    always_comb begin
        s_ready   = clr_done_reg && eng_idle;
        s_accept  = s_valid && s_ready;
        in_range  = (7'(s_cell_x) < 7'(MAP_COLUMNS)) && (7'(s_cell_y) < 7'(MAP_ROWS));
        wr_cell   = s_accept && !s_op && in_range;
        ram_we    = !clr_done_reg || wr_cell;
        ram_wa    = !clr_done_reg ? clr_addr_reg
                  : ADDR_W'(s_cell_y) * ADDR_W'(MAP_COLUMNS) + ADDR_W'(s_cell_x);
        ram_wd    = clr_done_reg && s_wall_bit;
        cmd.start_x   = s_start_x;
        cmd.start_y   = s_start_y;
        cmd.ray_angle = s_ray_angle;
        res_ready = !m_valid_reg || m_ready;
    end

    grm_ram #(
        .DATA_W (1),
        .DEPTH  (DEPTH)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_en   (ram_re),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    grm_engine #(
        .MAP_COLUMNS (MAP_COLUMNS),
        .MAP_ROWS    (MAP_ROWS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_accept && s_op),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .rd_en     (ram_re),
        .rd_addr   (ram_ra),
        .rd_data   (ram_rd),
        .res_ready (res_ready),
        .idle      (eng_idle),
        .done      (eng_done),
        .res       (eng_res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (eng_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (eng_done) begin
            m_res_reg <= eng_res;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_distance = m_res_reg.distance;
    assign m_end_x    = m_res_reg.end_x;
    assign m_end_y    = m_res_reg.end_y;

    `include "grid_ray_march_distance_assert.svh"

    `GRM_ASSERT_SAME(a_no_item_while_clearing, !clr_done_reg, !s_ready)
    `GRM_ASSERT_SAME(a_no_item_while_busy, !eng_idle, !s_ready)
    `GRM_ASSERT_SAME(a_result_not_overwritten, eng_done, !m_valid_reg || m_ready)
    `GRM_ASSERT_NEXT(a_cast_starts_engine, s_accept && s_op, !eng_idle)
endmodule
